[rtl/setl_pkg.sv]
// Shared types and constants for the sorted expiry timer list.
// Used by the cell, the controller, the top level and the checker.
`timescale 1ns / 1ps

package setl_pkg;

  localparam int TIMERS    = 32;
  localparam int TIME_BITS = 32;
  localparam int HDL_W     = 5;
  localparam int TAG_W     = 32;
  localparam int PORT_W    = 32;
  localparam int EXP_W     = (TIME_BITS < PORT_W) ? TIME_BITS : PORT_W;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_ADJUST = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXPIRED  = 3'd1;
  localparam logic [2:0] ST_NONE     = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_INACTIVE = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_MARK
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [HDL_W-1:0]       hdl;
    logic [EXP_W-1:0]       exp;
    logic [TAG_W-1:0]       tag;
  } cell_cmd_t;

  typedef struct packed {
    logic                   vld;
    logic [HDL_W-1:0]       hdl;
    logic [EXP_W-1:0]       exp;
    logic [TAG_W-1:0]       tag;
  } cell_data_t;

endpackage

[rtl/sorted_expiry_timer_list.sv]
// Top level of the sorted expiry timer list: a row of timer cells kept in
// expiry order plus the sequencer. Depends on setl_pkg, setl_cell, setl_ctrl.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   in      | input     | in_valid/in_ready, in_kind, in_handle, in_expiry,
//           |           | in_user_tag, in_now
//   out     | output    | out_valid/out_ready, out_status, out_handle, out_tag,
//           |           | out_last
//
// Adjust and delete take longer the more timers are queued behind the removed one, as
// the hole walks the chain. A tick gives one result per popped timer. Output stalls
// hold the sequencer until the result is taken.
// One item at a time; the next is taken once the result sits in the out register.
// Reset clears the cell valid bits and the sequencer; no clearing pass.
`timescale 1ns / 1ps

module sorted_expiry_timer_list (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  logic [setl_pkg::HDL_W-1:0]       in_handle,
  input  logic [setl_pkg::PORT_W-1:0]      in_expiry,
  input  logic [setl_pkg::TAG_W-1:0]       in_user_tag,
  input  logic [setl_pkg::PORT_W-1:0]      in_now,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [setl_pkg::HDL_W-1:0]       out_handle,
  output logic [setl_pkg::TAG_W-1:0]       out_tag,
  output logic                             out_last
);
  import setl_pkg::*;

  cell_cmd_t                cmd;
  cell_data_t [TIMERS-1:0]  cells;
  logic       [TIMERS-1:0]  pos;
  logic       [TIMERS-1:0]  gaps;

  setl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_handle   (in_handle),
    .in_expiry   (in_expiry),
    .in_user_tag (in_user_tag),
    .in_now      (in_now),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_handle  (out_handle),
    .out_tag     (out_tag),
    .out_last    (out_last),
    .cmd         (cmd),
    .cells       (cells),
    .gaps        (gaps)
  );

  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    cell_data_t left_data;
    cell_data_t right_data;
    logic       left_pos;
    logic       left_gap;

    if (i == 0) begin : g_head
      assign left_data = '0;
      assign left_pos  = 1'b0;
      assign left_gap  = 1'b0;
    end else begin : g_mid
      assign left_data = cells[i-1];
      assign left_pos  = pos[i-1];
      assign left_gap  = gaps[i-1];
    end

    if (i == TIMERS - 1) begin : g_tail
      assign right_data = '0;
    end else begin : g_body
      assign right_data = cells[i+1];
    end

    setl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_data  (left_data),
      .left_pos   (left_pos),
      .left_gap   (left_gap),
      .right_data (right_data),
      .data       (cells[i]),
      .pos        (pos[i]),
      .gap        (gaps[i])
    );
  end

endmodule

[rtl/setl_cell.sv]
// One slot of the sorted chain: holds a timer, shifts to or from its neighbors.
// Depends on setl_pkg.
`timescale 1ns / 1ps

module setl_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  setl_pkg::cell_cmd_t cmd,
  input  setl_pkg::cell_data_t left_data,
  input  logic                left_pos,
  input  logic                left_gap,
  input  setl_pkg::cell_data_t right_data,
  output setl_pkg::cell_data_t data,
  output logic                pos,
  output logic                gap
);
  import setl_pkg::*;

  logic             vld_r, vld_nxt;
  logic             gap_r, gap_nxt;
  logic [HDL_W-1:0] hdl_r, hdl_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  assign data = '{vld: vld_r, hdl: hdl_r, exp: exp_r, tag: tag_r};
  assign gap  = gap_r;
  // insertion point lies at or before this cell
  assign pos  = !vld_r || (exp_r > cmd.exp);

  always_comb begin
    vld_nxt = vld_r;
    hdl_nxt = hdl_r;
    exp_nxt = exp_r;
    tag_nxt = tag_r;
    gap_nxt = gap_r;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (pos && !left_pos) begin
          vld_nxt = 1'b1;
          hdl_nxt = cmd.hdl;
          exp_nxt = cmd.exp;
          tag_nxt = cmd.tag;
        end else if (pos) begin
          vld_nxt = left_data.vld;
          hdl_nxt = left_data.hdl;
          exp_nxt = left_data.exp;
          tag_nxt = left_data.tag;
        end
      end
      CELL_POP: begin
        vld_nxt = right_data.vld;
        hdl_nxt = right_data.hdl;
        exp_nxt = right_data.exp;
        tag_nxt = right_data.tag;
      end
      CELL_MARK: begin
        gap_nxt = vld_r && (hdl_r == cmd.hdl);
      end
      default: begin
        // gap walks right one cell per cycle, pulling the tail left
        if (gap_r) begin
          gap_nxt = 1'b0;
          if (right_data.vld) begin
            hdl_nxt = right_data.hdl;
            exp_nxt = right_data.exp;
            tag_nxt = right_data.tag;
          end else begin
            vld_nxt = 1'b0;
          end
        end else if (left_gap && vld_r) begin
          gap_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      gap_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      gap_r <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdl_r <= hdl_nxt;
    exp_r <= exp_nxt;
    tag_r <= tag_nxt;
  end

endmodule

[rtl/setl_ctrl.sv]
// Sequencer: decodes an item, drives the cell chain and owns the result register.
// Depends on setl_pkg.
`timescale 1ns / 1ps

module setl_ctrl (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_kind,
  input  logic [setl_pkg::HDL_W-1:0]              in_handle,
  input  logic [setl_pkg::PORT_W-1:0]             in_expiry,
  input  logic [setl_pkg::TAG_W-1:0]              in_user_tag,
  input  logic [setl_pkg::PORT_W-1:0]             in_now,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [2:0]                              out_status,
  output logic [setl_pkg::HDL_W-1:0]              out_handle,
  output logic [setl_pkg::TAG_W-1:0]              out_tag,
  output logic                                    out_last,
  output setl_pkg::cell_cmd_t                     cmd,
  input  setl_pkg::cell_data_t [setl_pkg::TIMERS-1:0] cells,
  input  logic [setl_pkg::TIMERS-1:0]             gaps
);
  import setl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_PLACE,
    S_POP,
    S_RESP
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [HDL_W-1:0] hdl_r, hdl_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [EXP_W-1:0] now_r, now_nxt;
  logic [2:0]       res_r, res_nxt;
  logic             pend_r, pend_nxt;
  logic [HDL_W-1:0] pend_hdl_r, pend_hdl_nxt;
  logic [TAG_W-1:0] pend_tag_r, pend_tag_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [HDL_W-1:0] out_handle_r, out_handle_nxt;
  logic [TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             hvalid;
  logic             active;
  logic [TAG_W-1:0] mtag;
  logic             full;
  logic             due;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_handle = out_handle_r;
  assign out_tag    = out_tag_r;
  assign out_last   = out_last_r;

  assign out_free = !out_valid_r || out_ready;
  assign hvalid   = 32'(hdl_r) < 32'(TIMERS);
  assign full     = cells[TIMERS-1].vld;
  assign due      = cells[0].vld && (cells[0].exp <= now_r);

  always_comb begin
    active = 1'b0;
    mtag   = '0;
    for (int i = 0; i < TIMERS; i++) begin
      if (cells[i].vld && (cells[i].hdl == hdl_r)) begin
        active = 1'b1;
        mtag   = mtag | cells[i].tag;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    hdl_nxt        = hdl_r;
    exp_nxt        = exp_r;
    tag_nxt        = tag_r;
    now_nxt        = now_r;
    res_nxt        = res_r;
    pend_nxt       = pend_r;
    pend_hdl_nxt   = pend_hdl_r;
    pend_tag_nxt   = pend_tag_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    cmd            = '{op: CELL_HOLD, hdl: hdl_r, exp: exp_r, tag: tag_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          hdl_nxt   = in_handle;
          exp_nxt   = in_expiry[EXP_W-1:0];
          tag_nxt   = in_user_tag;
          now_nxt   = in_now[EXP_W-1:0];
          pend_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (kind_r) inside
          KIND_ADD: begin
            if (!hvalid || active || full) begin
              res_nxt   = ST_BUSY;
              state_nxt = S_RESP;
            end else begin
              res_nxt   = ST_OK;
              state_nxt = S_PLACE;
            end
          end
          KIND_ADJUST, KIND_DELETE: begin
            if (!hvalid || !active) begin
              res_nxt   = ST_INACTIVE;
              state_nxt = S_RESP;
            end else begin
              res_nxt   = ST_OK;
              tag_nxt   = mtag;
              cmd.op    = CELL_MARK;
              state_nxt = S_WALK;
            end
          end
          default: begin
            state_nxt = S_POP;
          end
        endcase
      end
      S_WALK: begin
        if (!(|gaps)) begin
          state_nxt = (kind_r == KIND_ADJUST) ? S_PLACE : S_RESP;
        end
      end
      S_PLACE: begin
        cmd.op    = CELL_INSERT;
        state_nxt = S_RESP;
      end
      S_POP: begin
        if (pend_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EXPIRED;
            out_handle_nxt = pend_hdl_r;
            out_tag_nxt    = pend_tag_r;
            out_last_nxt   = !due;
            if (due) begin
              cmd.op       = CELL_POP;
              pend_hdl_nxt = cells[0].hdl;
              pend_tag_nxt = cells[0].tag;
            end else begin
              pend_nxt  = 1'b0;
              state_nxt = S_IDLE;
            end
          end
        end else if (due) begin
          cmd.op       = CELL_POP;
          pend_nxt     = 1'b1;
          pend_hdl_nxt = cells[0].hdl;
          pend_tag_nxt = cells[0].tag;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NONE;
          out_handle_nxt = '0;
          out_tag_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_handle_nxt = hdl_r;
          out_tag_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    hdl_r        <= hdl_nxt;
    exp_r        <= exp_nxt;
    tag_r        <= tag_nxt;
    now_r        <= now_nxt;
    res_r        <= res_nxt;
    pend_hdl_r   <= pend_hdl_nxt;
    pend_tag_r   <= pend_tag_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

[rtl/setl_chk.sv]
// Port-level checker for the sorted expiry timer list, bound to the top level.
// Depends on setl_pkg and sorted_expiry_timer_list.
`timescale 1ns / 1ps

module setl_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  out_status,
  input logic [setl_pkg::HDL_W-1:0]  out_handle,
  input logic [setl_pkg::TAG_W-1:0]  out_tag,
  input logic                        out_last
);
  import setl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_handle) && $stable(out_tag) && $stable(out_last))
    else $error("result changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_EXPIRED) |-> out_last)
    else $error("non-expiry result without last");

  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_EXPIRED) |-> (out_tag == '0))
    else $error("tag set on non-expiry result");

  a_none_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NONE) |-> (out_handle == '0))
    else $error("nothing-expired result with a handle");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sorted_expiry_timer_list setl_chk u_setl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_handle (out_handle),
  .out_tag    (out_tag),
  .out_last   (out_last)
);

[bench/tb_sorted_expiry_timer_list.sv]
// Testbench for sorted_expiry_timer_list: directed and random add/adjust/delete/tick
// items against an in-bench timer list predictor and scoreboard.
// Depends on setl_pkg and the sorted_expiry_timer_list RTL.
`timescale 1ns / 1ps

module tb_sorted_expiry_timer_list;
  import setl_pkg::*;

  localparam int MAX_SHOWN = 10;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_kind;
  logic [HDL_W-1:0]    in_handle;
  logic [PORT_W-1:0]   in_expiry;
  logic [TAG_W-1:0]    in_user_tag;
  logic [PORT_W-1:0]   in_now;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          out_status;
  logic [HDL_W-1:0]    out_handle;
  logic [TAG_W-1:0]    out_tag;
  logic                out_last;

  bit no_idle;
  bit hold_req;

  typedef struct packed {
    logic [2:0]       status;
    logic [HDL_W-1:0] hdl;
    logic [TAG_W-1:0] tag;
    logic             last;
  } timer_result_t;

  class timer_list_scoreboard;
    timer_result_t    due_q[$];
    logic [HDL_W-1:0] order_q[$];
    logic [EXP_W-1:0] exp_of[TIMERS];
    logic [TAG_W-1:0] tag_of[TIMERS];
    bit               live[TIMERS];
    int               errors;

    function void push_result(logic [2:0] st, logic [HDL_W-1:0] h, logic [TAG_W-1:0] t,
                              logic l);
      timer_result_t r;
      r.status = st;
      r.hdl    = h;
      r.tag    = t;
      r.last   = l;
      due_q.push_back(r);
    endfunction

    // goes after every timer with an equal or earlier expiry
    function void place(logic [HDL_W-1:0] h);
      int pos;
      pos = 0;
      while (pos < order_q.size() && exp_of[order_q[pos]] <= exp_of[h]) pos++;
      order_q.insert(pos, h);
    endfunction

    function void note_item(logic [1:0] k, logic [HDL_W-1:0] h, logic [PORT_W-1:0] e,
                            logic [TAG_W-1:0] t, logic [PORT_W-1:0] n);
      logic [HDL_W-1:0] top;
      int               popped;
      popped = 0;
      case (k) inside
        KIND_ADD: begin
          if (live[h] || order_q.size() >= TIMERS) begin
            push_result(ST_BUSY, h, '0, 1'b1);
          end else begin
            exp_of[h] = e[EXP_W-1:0];
            tag_of[h] = t;
            live[h]   = 1'b1;
            place(h);
            push_result(ST_OK, h, '0, 1'b1);
          end
        end
        KIND_ADJUST, KIND_DELETE: begin
          if (!live[h]) begin
            push_result(ST_INACTIVE, h, '0, 1'b1);
          end else begin
            for (int i = 0; i < order_q.size(); i++) begin
              if (order_q[i] == h) begin
                order_q.delete(i);
                break;
              end
            end
            if (k == KIND_ADJUST) begin
              exp_of[h] = e[EXP_W-1:0];
              place(h);
            end else begin
              live[h] = 1'b0;
            end
            push_result(ST_OK, h, '0, 1'b1);
          end
        end
        default: begin
          while (order_q.size() > 0 && exp_of[order_q[0]] <= n[EXP_W-1:0]) begin
            top = order_q.pop_front();
            live[top] = 1'b0;
            push_result(ST_EXPIRED, top, tag_of[top], 1'b0);
            popped++;
          end
          if (popped == 0) push_result(ST_NONE, '0, '0, 1'b1);
          else due_q[due_q.size()-1].last = 1'b1;
        end
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [HDL_W-1:0] h, logic [TAG_W-1:0] t,
                               logic l);
      timer_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t unexpected result: status=%0d handle=%0d tag=%h last=%0b",
                   $realtime, st, h, t, l);
        return;
      end
      want = due_q.pop_front();
      if (st !== want.status || h !== want.hdl || t !== want.tag || l !== want.last) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("%0t mismatch: exp status=%0d handle=%0d tag=%h last=%0b",
                   $realtime, want.status, want.hdl, want.tag, want.last);
          $display("  got status=%0d handle=%0d tag=%h last=%0b", st, h, t, l);
        end
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  timer_list_scoreboard sb = new();

  sorted_expiry_timer_list dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_handle, out_tag, out_last);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = no_idle || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    #5000000;
    $display("tb_sorted_expiry_timer_list: FAIL");
    $finish;
  end

  task automatic send_item(logic [1:0] k, logic [HDL_W-1:0] h, logic [PORT_W-1:0] e,
                           logic [TAG_W-1:0] t, logic [PORT_W-1:0] n);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_kind     = k;
    in_handle   = h;
    in_expiry   = e;
    in_user_tag = t;
    in_now      = n;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, h, e, t, n);
  endtask

  task automatic do_add(logic [HDL_W-1:0] h, logic [PORT_W-1:0] e, logic [TAG_W-1:0] t);
    send_item(KIND_ADD, h, e, t, $urandom);
  endtask

  task automatic do_adjust(logic [HDL_W-1:0] h, logic [PORT_W-1:0] e);
    send_item(KIND_ADJUST, h, e, $urandom, $urandom);
  endtask

  task automatic do_delete(logic [HDL_W-1:0] h);
    send_item(KIND_DELETE, h, $urandom, $urandom, $urandom);
  endtask

  task automatic do_tick(logic [PORT_W-1:0] n);
    send_item(KIND_TICK, HDL_W'($urandom), $urandom, $urandom, n);
  endtask

  function automatic logic [HDL_W-1:0] pick_handle(bit want_live);
    int start;
    start = $urandom_range(TIMERS-1);
    for (int i = 0; i < TIMERS; i++)
      if (sb.live[(start + i) % TIMERS] == want_live) return HDL_W'((start + i) % TIMERS);
    return HDL_W'(start);
  endfunction

  function automatic logic [PORT_W-1:0] near_time(logic [PORT_W-1:0] base);
    if ($urandom_range(9) == 0) return $urandom;
    return base + $urandom_range(1, 200);
  endfunction

  initial begin
    logic [PORT_W-1:0] cur_now;
    logic [PORT_W-1:0] base;
    logic [HDL_W-1:0]  hsel;
    int                r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = KIND_ADD;
    in_handle   = '0;
    in_expiry   = '0;
    in_user_tag = '0;
    in_now      = '0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    do_tick('0);
    do_delete(5'd5);
    do_adjust(5'd31, 32'd7);
    do_add(5'd0, 32'h0, 32'h0);
    do_add(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    do_add(5'd1, 32'd100, 32'hA5A5_A5A5);
    do_add(5'd2, 32'd100, 32'h5A5A_5A5A);
    do_add(5'd3, 32'd50, 32'h1234_5678);
    do_add(5'd1, 32'd1, 32'd1);
    do_adjust(5'd3, 32'd100);
    do_adjust(5'd31, 32'd10);
    do_delete(5'd2);
    do_delete(5'd2);
    do_tick(32'd0);
    do_tick(32'd9);
    do_tick(32'd100);
    do_tick(32'hFFFF_FFFF);
    do_add(5'd4, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
    do_tick(32'hFFFF_FFFE);
    do_tick(32'hFFFF_FFFF);

    // sender pauses until every result is back
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // full table, busy adds, adjusts and a delete on it, then one tick pops all of it
    base = $urandom;
    for (int i = 0; i < TIMERS; i++)
      do_add(pick_handle(1'b0), base + $urandom_range(0, 7), $urandom);
    do_add(HDL_W'($urandom), $urandom, $urandom);
    do_adjust(pick_handle(1'b1), base + $urandom_range(0, 7));
    do_adjust(pick_handle(1'b1), base + $urandom_range(0, 7));
    hsel = pick_handle(1'b1);
    do_delete(hsel);
    do_add(hsel, base + 3, $urandom);
    do_add(pick_handle(1'b1), $urandom, $urandom);
    do_tick(32'hFFFF_FFFF);

    // receiver holds off while items keep coming
    hold_req = 1'b1;
    cur_now  = $urandom_range(1000);
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 2) do_tick(cur_now + 50);
      else do_add(pick_handle(1'b0), near_time(cur_now), $urandom);
    end

    for (int i = 0; i < 40; i++) begin
      no_idle = (i >= 10 && i < 30);
      r = $urandom_range(99);
      if (r < 40) begin
        hsel = ($urandom_range(4) == 0) ? HDL_W'($urandom) : pick_handle(1'b0);
        do_add(hsel, near_time(cur_now), $urandom);
      end else if (r < 55) begin
        hsel = ($urandom_range(5) == 0) ? HDL_W'($urandom) : pick_handle(1'b1);
        do_adjust(hsel, near_time(cur_now));
      end else if (r < 67) begin
        hsel = ($urandom_range(5) == 0) ? HDL_W'($urandom) : pick_handle(1'b1);
        do_delete(hsel);
      end else if (r < 70) begin
        do_tick($urandom);
      end else begin
        cur_now = cur_now + $urandom_range(0, 120);
        do_tick(cur_now);
      end
    end
    no_idle = 1'b0;
    do_tick(32'hFFFF_FFFF);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_sorted_expiry_timer_list: PASS");
    end else begin
      $display("tb_sorted_expiry_timer_list: FAIL");
    end
    $finish;
  end

endmodule
